>>> hdl/pcf_pkg.sv
// ============================================================================
// pcf_pkg: shared constants for pose composition
// Data width, register indexes and opcodes.
// ============================================================================
`default_nettype none
package pcf_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int NUM_REGS   = 7;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] REG_POS_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_POS_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_POS_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROT_W = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROT_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROT_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROT_Z = 3'd6;

    localparam logic OP_COMPOSE  = 1'b0;
    localparam logic OP_RELATIVE = 1'b1;
endpackage
`default_nettype wire

>>> hdl/pcf_stream_if.sv
// ============================================================================
// pcf_stream_if: valid/ready channel carrying a pose payload
// Payload type is a parameter so input and output channels share the file.
// ============================================================================
`default_nettype none
interface pcf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/pcf_qmul.sv
// ============================================================================
// pcf_qmul: pipelined fixed-point Hamilton product
// Stage 1 registers the 16 rounded products, stage 2 sums and saturates.
// Operands are W+1 bits signed so conjugates never wrap.
// ============================================================================
`default_nettype none
module pcf_qmul #(
    parameter int W = pcf_pkg::DATA_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [W:0]   i_a [4],
    input  wire logic signed [W:0]   i_b [4],
    output logic signed [W-1:0]      o_c [4]
);
    localparam int QF = W - 2;
    localparam int PW = 2 * W + 2;
    localparam int RW = PW - QF;
    localparam int SW = RW + 2;

    logic signed [RW-1:0] r_prod [16];
    logic signed [W-1:0]  r_c    [4];

    function automatic logic signed [RW-1:0] mulr(input logic signed [W:0] x,
                                                  input logic signed [W:0] y);
        logic signed [PW-1:0] p;
        p = PW'(x) * PW'(y) + (PW'(1) <<< (QF - 1));
        return p[PW-1:QF];
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        mx = SW'((SW'(1) <<< (W - 1)) - 1);
        mn = -mx - SW'(1);
        if (v > mx) return mx[W-1:0];
        if (v < mn) return mn[W-1:0];
        return v[W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[4*i+j] <= mulr(i_a[i], i_b[j]);
                end
            end
        end
    end

    // products indexed a*4+b
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= sat(SW'(r_prod[0]) - SW'(r_prod[5]) - SW'(r_prod[10]) - SW'(r_prod[15]));
            r_c[1] <= sat(SW'(r_prod[1]) + SW'(r_prod[4]) + SW'(r_prod[11]) - SW'(r_prod[14]));
            r_c[2] <= sat(SW'(r_prod[2]) - SW'(r_prod[7]) + SW'(r_prod[8]) + SW'(r_prod[13]));
            r_c[3] <= sat(SW'(r_prod[3]) + SW'(r_prod[6]) - SW'(r_prod[9]) + SW'(r_prod[12]));
        end
    end

    assign o_c = r_c;
endmodule
`default_nettype wire

>>> hdl/pose_compose_by_frame_top.sv
// ============================================================================
// pose_compose_by_frame_top: rigid pose transform by a configured frame
// ============================================================================
// Accepts one pose per cycle while not stalled and returns one transformed pose
// per pose, in order, through six register stages: a prep stage, two
// quaternion products of two stages each (rotation product runs in parallel
// with the second), and a final output stage that adds the frame position in
// compose mode. The whole pipeline advances when the output register is free
// or being emptied.
// Frame registers must only be written while the pipeline is empty.
// ============================================================================
`default_nettype none
module pose_compose_by_frame_top #(
    parameter int DATA_WIDTH = pcf_pkg::DATA_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcf_pkg::IDX_W-1:0]         i_cfg_idx,
    input  wire logic [DATA_WIDTH-1:0]             i_cfg_data,
    pcf_stream_if.sink                             i_pose,
    pcf_stream_if.source                           o_pose
);
    localparam int W      = DATA_WIDTH;
    localparam int QF     = W - 2;
    localparam int STAGES = 6;

    logic signed [W-1:0] r_frame [pcf_pkg::NUM_REGS];
    logic [STAGES-1:0]   r_vld;
    logic                adv;

    assign adv          = !o_pose.valid || o_pose.ready;
    assign i_pose.ready = adv;
    assign o_pose.valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pcf_pkg::NUM_REGS; i++) r_frame[i] <= '0;
            r_frame[pcf_pkg::REG_ROT_W] <= W'(1) << QF;
        end else if (i_cfg_we && i_cfg_idx < pcf_pkg::IDX_W'(pcf_pkg::NUM_REGS)) begin
            r_frame[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[STAGES-2:0], i_pose.valid};
    end

    function automatic logic signed [W-1:0] satw(input logic signed [W+1:0] v);
        logic signed [W+1:0] mx;
        mx = (W+2)'((W+2)'(1) <<< (W - 1)) - 1;
        if (v > mx) return mx[W-1:0];
        if (v < -mx - 1) return W'(-mx - 1);
        return v[W-1:0];
    endfunction

    // frame quaternion and its conjugate, W+1 bits
    logic signed [W:0] q [4];
    logic signed [W:0] qc [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q[i]  = (W+1)'(r_frame[3+i]);
            qc[i] = (i == 0) ? q[i] : -q[i];
        end
    end

    // stage 0: position prep
    logic                r_op [5];
    logic signed [W:0]   r_p0 [4];
    logic signed [W:0]   r_rot0 [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op[0]   <= i_pose.payload.op;
            r_p0[0]   <= '0;
            r_rot0[0] <= (W+1)'(i_pose.payload.pose_rot_w);
            r_rot0[1] <= (W+1)'(i_pose.payload.pose_rot_x);
            r_rot0[2] <= (W+1)'(i_pose.payload.pose_rot_y);
            r_rot0[3] <= (W+1)'(i_pose.payload.pose_rot_z);
            if (i_pose.payload.op == pcf_pkg::OP_RELATIVE) begin
                r_p0[1] <= (W+1)'(satw((W+2)'(i_pose.payload.pose_pos_x) - (W+2)'(r_frame[0])));
                r_p0[2] <= (W+1)'(satw((W+2)'(i_pose.payload.pose_pos_y) - (W+2)'(r_frame[1])));
                r_p0[3] <= (W+1)'(satw((W+2)'(i_pose.payload.pose_pos_z) - (W+2)'(r_frame[2])));
            end else begin
                r_p0[1] <= (W+1)'(i_pose.payload.pose_pos_x);
                r_p0[2] <= (W+1)'(i_pose.payload.pose_pos_y);
                r_p0[3] <= (W+1)'(i_pose.payload.pose_pos_z);
            end
            for (int i = 1; i < 5; i++) r_op[i] <= r_op[i-1];
        end
    end

    logic signed [W:0]   m1_b [4];
    logic signed [W:0]   m2_a [4];
    logic signed [W:0]   m2_b [4];
    logic signed [W:0]   mr_a [4];
    logic signed [W-1:0] t    [4];
    logic signed [W-1:0] u    [4];
    logic signed [W-1:0] rot  [4];
    logic signed [W:0]   r_rot1 [4];
    logic signed [W:0]   r_rot2 [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m1_b[i] = (r_op[0] == pcf_pkg::OP_RELATIVE) ? q[i] : qc[i];
            m2_a[i] = (r_op[2] == pcf_pkg::OP_RELATIVE) ? qc[i] : q[i];
            m2_b[i] = (W+1)'(t[i]);
            mr_a[i] = (r_op[2] == pcf_pkg::OP_RELATIVE) ? qc[i] : q[i];
        end
    end

    pcf_qmul #(.W(W)) u_inner (.i_clk(i_clk), .i_en(adv), .i_a(r_p0), .i_b(m1_b), .o_c(t));
    pcf_qmul #(.W(W)) u_outer (.i_clk(i_clk), .i_en(adv), .i_a(m2_a), .i_b(m2_b), .o_c(u));
    pcf_qmul #(.W(W)) u_rot   (.i_clk(i_clk), .i_en(adv), .i_a(mr_a), .i_b(r_rot2),
                               .o_c(rot));

    // delay pose rotation two stages to line up with the outer product
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rot1 <= r_rot0;
            r_rot2 <= r_rot1;
        end
    end

    // final stage: output register, with frame position added in compose mode
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_op[4] == pcf_pkg::OP_RELATIVE) begin
                o_pose.payload.out_pos_x <= u[1];
                o_pose.payload.out_pos_y <= u[2];
                o_pose.payload.out_pos_z <= u[3];
            end else begin
                o_pose.payload.out_pos_x <= satw((W+2)'(r_frame[0]) + (W+2)'(u[1]));
                o_pose.payload.out_pos_y <= satw((W+2)'(r_frame[1]) + (W+2)'(u[2]));
                o_pose.payload.out_pos_z <= satw((W+2)'(r_frame[2]) + (W+2)'(u[3]));
            end
            o_pose.payload.out_rot_w <= rot[0];
            o_pose.payload.out_rot_x <= rot[1];
            o_pose.payload.out_rot_y <= rot[2];
            o_pose.payload.out_rot_z <= rot[3];
        end
    end
endmodule
`default_nettype wire

>>> hdl/pcf_checker.sv
// ============================================================================
// pcf_checker: port-level checks on the pose pipeline
// Bound to the top level; observes handshakes and that output valid holds while stalled.
// ============================================================================
`default_nettype none
module pcf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready) else $error("ready while stalled");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready) else $error("not ready when output empty");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid) else $error("output dropped");
endmodule

bind pose_compose_by_frame_top pcf_checker u_pcf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_pose.valid), .i_in_ready(i_pose.ready),
    .i_out_valid(o_pose.valid), .i_out_ready(o_pose.ready)
);
`default_nettype wire
